/* rtl/core/abkf_pkg.sv */
package abkf_pkg;

    localparam int CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_PROCESS_NOISE_ANGLE = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_PROCESS_NOISE_BIAS  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_MEASUREMENT_NOISE   = 2'd2;

    localparam logic [31:0] RESET_PROCESS_NOISE_ANGLE = 32'd4294967;
    localparam logic [31:0] RESET_PROCESS_NOISE_BIAS  = 32'd12884902;
    localparam logic [31:0] RESET_MEASUREMENT_NOISE   = 32'd128849019;

    localparam logic ACTION_UPDATE    = 1'b0;
    localparam logic ACTION_SET_ANGLE = 1'b1;

    // restoring divider runs over the whole 80-bit dividend
    localparam int DivSteps = 80;

    localparam logic signed [63:0] LIM32 = 64'sd2147483647;
    localparam logic signed [63:0] LIM48 = 64'sd140737488355327;

    typedef struct packed {
        logic               action;
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
        logic        [23:0] time_step;
    } abkf_sample_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
        logic signed [31:0] unbiased_rate;
    } abkf_result_t;

    typedef struct packed {
        logic               start;
        logic signed [48:0] a;
        logic signed [48:0] b;
        logic               shift32;
    } abkf_mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } abkf_mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic signed [47:0] num;
        logic        [47:0] den;
    } abkf_div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [47:0] res;
    } abkf_div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED_ANGLE,
        ST_PRED_T,
        ST_PRED_U,
        ST_PRED_AA,
        ST_PRED_BB,
        ST_INNOV,
        ST_GAIN0,
        ST_GAIN1,
        ST_CORR_ANGLE,
        ST_CORR_BIAS,
        ST_CORR_AA,
        ST_CORR_AB,
        ST_CORR_BA,
        ST_CORR_BB,
        ST_RESULT
    } abkf_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > LIM32) begin
            return 32'sh7fffffff;
        end
        else if (v < -LIM32 - 64'sd1) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > LIM48) begin
            return 48'sh7fffffffffff;
        end
        else if (v < -LIM48 - 64'sd1) begin
            return 48'sh800000000000;
        end
        return v[47:0];
    endfunction

endpackage

/* rtl/core/abkf_mul.sv */
module abkf_mul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  abkf_pkg::abkf_mul_req_t req,
    output abkf_pkg::abkf_mul_rsp_t rsp
);
    import abkf_pkg::*;

    logic        [47:0] ma_reg;
    logic        [47:0] mb_reg;
    logic               neg_reg;
    logic               sh32_reg;
    logic        [95:0] acc_reg;
    logic        [2:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [63:0] res_reg;

    logic        [48:0] abs_a;
    logic        [48:0] abs_b;
    logic        [23:0] a_half;
    logic        [23:0] b_half;
    logic        [47:0] pp;
    logic        [95:0] pp_shifted;
    logic        [95:0] prod_shifted;
    logic        [62:0] mag;

    assign abs_a = req.a[48] ? 49'(-req.a) : 49'(req.a);
    assign abs_b = req.b[48] ? 49'(-req.b) : 49'(req.b);

    // one 24x24 partial product per cycle
    assign a_half = cnt_reg[0] ? ma_reg[47:24] : ma_reg[23:0];
    assign b_half = cnt_reg[1] ? mb_reg[47:24] : mb_reg[23:0];
    assign pp     = a_half * b_half;

    always_comb
    begin
        pp_shifted = {48'd0, pp};
        if (cnt_reg[0] && cnt_reg[1]) begin
            pp_shifted = {pp, 48'd0};
        end
        else if (cnt_reg[0] || cnt_reg[1]) begin
            pp_shifted = {24'd0, pp, 24'd0};
        end
    end

    assign prod_shifted = sh32_reg ? (acc_reg >> 32) : (acc_reg >> 24);
    assign mag = (|prod_shifted[95:62]) ? {1'b1, 62'd0} : prod_shifted[62:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg) begin
            ma_reg   <= abs_a[47:0];
            mb_reg   <= abs_b[47:0];
            neg_reg  <= req.a[48] != req.b[48];
            sh32_reg <= req.shift32;
            acc_reg  <= '0;
        end
        else if (busy_reg) begin
            if (cnt_reg == 3'd4) begin
                res_reg <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            else begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

/* rtl/core/abkf_div.sv */
module abkf_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  abkf_pkg::abkf_div_req_t req,
    output abkf_pkg::abkf_div_rsp_t rsp
);
    import abkf_pkg::*;

    localparam int CntWidth = $clog2(DivSteps + 1);

    logic        [79:0]         dvd_reg;
    logic        [79:0]         quo_reg;
    logic        [47:0]         rem_reg;
    logic        [47:0]         den_reg;
    logic                       neg_reg;
    logic        [CntWidth-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic signed [47:0]         res_reg;

    logic [48:0] abs_num;
    logic [47:0] rem_shift;
    logic        fits;
    logic [46:0] mag;

    assign abs_num   = req.num[47] ? 49'(-49'(req.num)) : 49'(req.num);
    assign rem_shift = {rem_reg[46:0], dvd_reg[79]};
    assign fits      = rem_shift >= den_reg;
    assign mag       = (|quo_reg[79:47]) ? 47'(LIM48) : quo_reg[46:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                if (cnt_reg == CntWidth'(DivSteps)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else begin
                    cnt_reg <= cnt_reg + CntWidth'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg) begin
            dvd_reg <= {abs_num[47:0], 32'd0};
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= req.den;
            neg_reg <= req.num[47];
        end
        else if (busy_reg) begin
            if (cnt_reg == CntWidth'(DivSteps)) begin
                res_reg <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            else begin
                dvd_reg <= {dvd_reg[78:0], 1'b0};
                quo_reg <= {quo_reg[78:0], fits};
                rem_reg <= fits ? rem_shift - den_reg : rem_shift;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

/* rtl/core/angle_bias_kalman_filter.sv */
// sequence: a set-angle beat goes straight to the result state;
// an update beat makes two gain divides (80 steps each)
// and ten shared-multiplier passes, or only the prediction passes when S is not positive
// flow: one beat at a time, sample_stall stays high until the result is posted
// reset: asynchronous active low, state and covariance cleared, noise registers preset
module angle_bias_kalman_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  abkf_pkg::abkf_sample_t                 sample,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output abkf_pkg::abkf_result_t                 result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [abkf_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [31:0]                            cfg_data
);
    import abkf_pkg::*;

    // sequencer
    abkf_state_t state_reg;
    abkf_state_t state_next;
    logic        issued_reg;

    // noise registers
    logic [31:0] qa_reg;
    logic [31:0] qb_reg;
    logic [31:0] r_reg;

    // filter state
    logic signed [31:0] angle_reg;
    logic signed [31:0] bias_reg;
    logic signed [47:0] paa_reg;
    logic signed [47:0] pab_reg;
    logic signed [47:0] pba_reg;
    logic signed [47:0] pbb_reg;

    // per-update working values
    logic signed [31:0] meas_reg;
    logic        [23:0] dt_reg;
    logic signed [31:0] rate_reg;
    logic signed [47:0] t_reg;
    logic signed [47:0] u_reg;
    logic signed [47:0] s_reg;
    logic signed [47:0] k0_reg;
    logic signed [47:0] k1_reg;
    logic signed [31:0] dif_reg;
    logic signed [47:0] p00_reg;
    logic signed [47:0] p01_reg;

    logic               result_valid_reg;
    abkf_result_t       result_reg;

    abkf_mul_req_t mul_req;
    abkf_mul_rsp_t mul_rsp;
    abkf_div_req_t div_req;
    abkf_div_rsp_t div_rsp;

    logic               accept;
    logic               post;
    logic signed [47:0] s_next;
    logic signed [48:0] dt_op;
    logic signed [48:0] qb_op;

    abkf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    abkf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;

    // result register frees up on the same edge it is taken
    assign post = (state_reg == ST_RESULT) && (!result_valid_reg || !result_stall);

    assign dt_op  = $signed({25'd0, dt_reg});
    assign qb_op  = $signed({17'd0, qb_reg});
    // innovation variance S = P00 + R
    assign s_next = sat48(64'(paa_reg) + $signed({32'd0, r_reg}));

    always_comb
    begin
        state_next      = state_reg;
        mul_req.start   = 1'b0;
        mul_req.a       = dt_op;
        mul_req.b       = 49'(rate_reg);
        mul_req.shift32 = 1'b0;
        div_req.start   = 1'b0;
        div_req.num     = paa_reg;
        div_req.den     = s_reg[47:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = (sample.action == ACTION_SET_ANGLE) ? ST_RESULT : ST_PRED_ANGLE;
                end
            end
            ST_PRED_ANGLE:
            begin
                mul_req.start = !issued_reg;
                if (mul_rsp.done) begin
                    state_next = ST_PRED_T;
                end
            end
            ST_PRED_T:
            begin
                mul_req.start = !issued_reg;
                mul_req.b     = 49'(pbb_reg);
                if (mul_rsp.done) begin
                    state_next = ST_PRED_U;
                end
            end
            ST_PRED_U:
            begin
                state_next = ST_PRED_AA;
            end
            ST_PRED_AA:
            begin
                mul_req.start = !issued_reg;
                mul_req.b     = 49'(u_reg);
                if (mul_rsp.done) begin
                    state_next = ST_PRED_BB;
                end
            end
            ST_PRED_BB:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = qb_op;
                mul_req.b     = dt_op;
                if (mul_rsp.done) begin
                    state_next = ST_INNOV;
                end
            end
            ST_INNOV:
            begin
                // no correction when S is not positive
                state_next = (s_next > 48'sd0) ? ST_GAIN0 : ST_RESULT;
            end
            ST_GAIN0:
            begin
                div_req.start = !issued_reg;
                if (div_rsp.done) begin
                    state_next = ST_GAIN1;
                end
            end
            ST_GAIN1:
            begin
                div_req.start = !issued_reg;
                div_req.num   = pba_reg;
                if (div_rsp.done) begin
                    state_next = ST_CORR_ANGLE;
                end
            end
            ST_CORR_ANGLE:
            begin
                mul_req.start   = !issued_reg;
                mul_req.a       = 49'(k0_reg);
                mul_req.b       = 49'(dif_reg);
                mul_req.shift32 = 1'b1;
                if (mul_rsp.done) begin
                    state_next = ST_CORR_BIAS;
                end
            end
            ST_CORR_BIAS:
            begin
                mul_req.start   = !issued_reg;
                mul_req.a       = 49'(k1_reg);
                mul_req.b       = 49'(dif_reg);
                mul_req.shift32 = 1'b1;
                if (mul_rsp.done) begin
                    state_next = ST_CORR_AA;
                end
            end
            ST_CORR_AA:
            begin
                mul_req.start   = !issued_reg;
                mul_req.a       = 49'(k0_reg);
                mul_req.b       = 49'(p00_reg);
                mul_req.shift32 = 1'b1;
                if (mul_rsp.done) begin
                    state_next = ST_CORR_AB;
                end
            end
            ST_CORR_AB:
            begin
                mul_req.start   = !issued_reg;
                mul_req.a       = 49'(k0_reg);
                mul_req.b       = 49'(p01_reg);
                mul_req.shift32 = 1'b1;
                if (mul_rsp.done) begin
                    state_next = ST_CORR_BA;
                end
            end
            ST_CORR_BA:
            begin
                mul_req.start   = !issued_reg;
                mul_req.a       = 49'(k1_reg);
                mul_req.b       = 49'(p00_reg);
                mul_req.shift32 = 1'b1;
                if (mul_rsp.done) begin
                    state_next = ST_CORR_BB;
                end
            end
            ST_CORR_BB:
            begin
                mul_req.start   = !issued_reg;
                mul_req.a       = 49'(k1_reg);
                mul_req.b       = 49'(p01_reg);
                mul_req.shift32 = 1'b1;
                if (mul_rsp.done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (post) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (mul_rsp.done || div_rsp.done) begin
                issued_reg <= 1'b0;
            end
            else if (mul_req.start || div_req.start) begin
                issued_reg <= 1'b1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qa_reg <= RESET_PROCESS_NOISE_ANGLE;
            qb_reg <= RESET_PROCESS_NOISE_BIAS;
            r_reg  <= RESET_MEASUREMENT_NOISE;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PROCESS_NOISE_ANGLE: qa_reg <= cfg_data;
                CFG_PROCESS_NOISE_BIAS:  qb_reg <= cfg_data;
                CFG_MEASUREMENT_NOISE:   r_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // filter state, updated as each multiply completes, in ST_PRED_U and on a set-angle beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            angle_reg <= '0;
            bias_reg  <= '0;
            paa_reg   <= '0;
            pab_reg   <= '0;
            pba_reg   <= '0;
            pbb_reg   <= '0;
        end
        else begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && sample.action == ACTION_SET_ANGLE) begin
                        angle_reg <= sample.measured_angle;
                    end
                end
                ST_PRED_ANGLE:
                begin
                    if (mul_rsp.done) begin
                        angle_reg <= sat32(64'(angle_reg) + mul_rsp.res);
                    end
                end
                ST_PRED_U:
                begin
                    pab_reg <= sat48(64'(pab_reg) - 64'(t_reg));
                    pba_reg <= sat48(64'(pba_reg) - 64'(t_reg));
                end
                ST_PRED_AA:
                begin
                    if (mul_rsp.done) begin
                        paa_reg <= sat48(64'(paa_reg) + mul_rsp.res);
                    end
                end
                ST_PRED_BB:
                begin
                    if (mul_rsp.done) begin
                        pbb_reg <= sat48(64'(pbb_reg) + mul_rsp.res);
                    end
                end
                ST_CORR_ANGLE:
                begin
                    if (mul_rsp.done) begin
                        angle_reg <= sat32(64'(angle_reg) + mul_rsp.res);
                    end
                end
                ST_CORR_BIAS:
                begin
                    if (mul_rsp.done) begin
                        bias_reg <= sat32(64'(bias_reg) + mul_rsp.res);
                    end
                end
                // shrink P from the values held before the correction
                ST_CORR_AA:
                begin
                    if (mul_rsp.done) begin
                        paa_reg <= sat48(64'(p00_reg) - mul_rsp.res);
                    end
                end
                ST_CORR_AB:
                begin
                    if (mul_rsp.done) begin
                        pab_reg <= sat48(64'(p01_reg) - mul_rsp.res);
                    end
                end
                ST_CORR_BA:
                begin
                    if (mul_rsp.done) begin
                        pba_reg <= sat48(64'(pba_reg) - mul_rsp.res);
                    end
                end
                ST_CORR_BB:
                begin
                    if (mul_rsp.done) begin
                        pbb_reg <= sat48(64'(pbb_reg) - mul_rsp.res);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working values need no reset
    always_ff @(posedge clk)
    begin
        if (accept) begin
            meas_reg <= sample.measured_angle;
            dt_reg   <= sample.time_step;
            // unbiased rate uses the bias from before this beat's correction
            rate_reg <= sat32(64'(sample.gyro_rate) - 64'(bias_reg));
        end
        if (state_reg == ST_PRED_T && mul_rsp.done) begin
            t_reg <= sat48(mul_rsp.res);
        end
        if (state_reg == ST_PRED_U) begin
            u_reg <= sat48(64'(t_reg) - 64'(pab_reg) - 64'(pba_reg)
                           + $signed({32'd0, qa_reg}));
        end
        if (state_reg == ST_INNOV) begin
            s_reg   <= s_next;
            p00_reg <= paa_reg;
            p01_reg <= pab_reg;
            dif_reg <= sat32(64'(meas_reg) - 64'(angle_reg));
        end
        if (state_reg == ST_GAIN0 && div_rsp.done) begin
            k0_reg <= div_rsp.res;
        end
        if (state_reg == ST_GAIN1 && div_rsp.done) begin
            k1_reg <= div_rsp.res;
        end
        if (post) begin
            result_reg.angle_estimate <= angle_reg;
            result_reg.bias_estimate  <= bias_reg;
            result_reg.unbiased_rate  <= rate_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else if (post) begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall) begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
